>>> rtl/kdwm_pkg.sv
// ----------------------------------------------------------------------------
// kdwm_pkg - kiwi drive wheel mixer shared definitions
// Fixed-point widths, constants, register indexes and sequencer states
// for the three omni wheel mixer.
// ----------------------------------------------------------------------------
package kdwm_pkg;

	// stick ADC resolution and fraction bits of the Q2.FRAC_BITS values
	localparam int ADC_BITS  = 12;
	localparam int FRAC_BITS = 15;

	localparam int DZ_BITS   = ADC_BITS - 1;
	// normalised stick value: range [-2, 2)
	localparam int Q_W       = FRAC_BITS + 3;
	// wheel mix sums, magnitude below 8
	localparam int M_W       = FRAC_BITS + 5;
	// divider remainder / divisor width
	localparam int DW        = (FRAC_BITS + 4 > ADC_BITS) ? FRAC_BITS + 4 : ADC_BITS;
	// shared multiplier operands and product
	localparam int MA_W      = FRAC_BITS + 2;
	localparam int MB_W      = (FRAC_BITS > 16) ? FRAC_BITS : 16;
	localparam int P_W       = MA_W + MB_W;
	// divider step counter, one quotient bit per step, FRAC_BITS+1 steps
	localparam int CNT_W     = $clog2(FRAC_BITS + 1);

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PULSE_W   = 11;
	localparam int GAIN_SH   = 16;

	localparam int Q_ONE_I   = 1 << FRAC_BITS;

	localparam logic signed [Q_W-1:0] Q_ONE_Q  = Q_W'(Q_ONE_I);
	localparam logic signed [Q_W-1:0] Q_HI_Q   = Q_W'(2 * Q_ONE_I - 1);
	localparam logic signed [M_W-1:0] Q_ONE_M  = M_W'(Q_ONE_I);
	localparam logic signed [M_W-1:0] Q_MONE_M = M_W'(-Q_ONE_I);

	// 0.866 in Q0.FRAC_BITS, truncated
	localparam logic [MB_W-1:0] K_866       = MB_W'((866 * Q_ONE_I) / 1000);
	localparam logic [MB_W-1:0] PULSE_SCALE = MB_W'(500);
	localparam logic [PULSE_W-1:0] PULSE_BASE = PULSE_W'(1000);
	localparam logic [PULSE_W-1:0] PULSE_MID  = PULSE_W'(1500);

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS);

	// register reset values
	localparam logic [ADC_BITS-1:0] NEUTRAL_RST = ADC_BITS'(2010);
	localparam logic [DZ_BITS-1:0]  DZ_RST      = DZ_BITS'(200);
	localparam logic [ADC_BITS-1:0] UPPER_RST   = ADC_BITS'(4020);
	localparam logic [15:0]         GAIN_RST    = 16'd32768;
	localparam logic [15:0]         TIMEOUT_RST = 16'd100;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DZ      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd4;

	// item command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// sequencer states
	typedef enum logic [10:0] {
		S_IDLE = 11'b000_0000_0001,
		S_NORM = 11'b000_0000_0010,
		S_NDIV = 11'b000_0000_0100,
		S_MRW  = 11'b000_0000_1000,
		S_MSY  = 11'b000_0001_0000,
		S_MIX  = 11'b000_0010_0000,
		S_WSET = 11'b000_0100_0000,
		S_WDIV = 11'b000_1000_0000,
		S_PMUL = 11'b001_0000_0000,
		S_PWR  = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

endpackage

>>> rtl/kiwi_drive_wheel_mixer.sv
// ----------------------------------------------------------------------------
// kiwi_drive_wheel_mixer - three omni wheel drive mixer with receive timeout
// Normalises three stick readings, mixes them into three wheel commands,
// rescales them when the largest exceeds one and maps them to servo pulses.
// Millisecond ticks run a timeout that drops the drive enable.
// ----------------------------------------------------------------------------
// Each item gives exactly one result. A tick item goes straight to the
// result stage. A sample item normalises the three stick channels in turn,
// each directly or by a division, then forms the rotation and sine products
// and the mix; when the largest wheel command exceeds one, it divides each
// wheel by that largest one, and it then maps each wheel to a pulse. The
// result stage waits while the previous result is still held. Both divisions
// use the single shared restoring divider, which retires one quotient bit
// per cycle over FRAC_BITS+1 steps, and the rotation, sine and pulse products
// use the shared multiplier. in_ready is high only while the sequencer is
// idle; a finished result waits in the output register while the next item is
// accepted. Configuration writes are always accepted (cfg_ready stays high)
// and must only be issued while the block is idle.
module kiwi_drive_wheel_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	// item input
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic [kdwm_pkg::ADC_BITS-1:0]      raw_x,
	input  logic [kdwm_pkg::ADC_BITS-1:0]      raw_y,
	input  logic [kdwm_pkg::ADC_BITS-1:0]      raw_z,
	// result output
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               drive_enable,
	output logic [kdwm_pkg::PULSE_W-1:0]       pulse_top,
	output logic [kdwm_pkg::PULSE_W-1:0]       pulse_left,
	output logic [kdwm_pkg::PULSE_W-1:0]       pulse_right,
	output logic                               stopped_now,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kdwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kdwm_pkg::CFG_W-1:0]         cfg_data
);

	import kdwm_pkg::*;

	function automatic logic [M_W-1:0] abs_m(input logic signed [M_W-1:0] a);
		abs_m = a[M_W-1] ? -a : a;
	endfunction

	function automatic logic [Q_W-1:0] abs_q(input logic signed [Q_W-1:0] a);
		abs_q = a[Q_W-1] ? -a : a;
	endfunction

	// control state
	state_t               state_q;
	logic [1:0]           idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 out_valid_q;
	logic                 drive_q;
	logic [15:0]          ms_q;
	logic [PULSE_W-1:0]   wheel_q [3];

	// configuration registers
	logic [ADC_BITS-1:0]  neutral_q;
	logic [DZ_BITS-1:0]   dz_q;
	logic [ADC_BITS-1:0]  upper_q;
	logic [15:0]          gain_q;
	logic [15:0]          timeout_q;

	// datapath registers
	logic                     cmd_q;
	logic [ADC_BITS-1:0]      raw_q [3];
	logic signed [Q_W-1:0]    v_q [3];
	logic signed [M_W-1:0]    m_q [3];
	logic signed [Q_W-1:0]    rw_q;
	logic [DW-1:0]            big_q;
	logic [DW-1:0]            rem_q;
	logic [DW-1:0]            dvs_q;
	logic [FRAC_BITS:0]       num_q;
	logic [FRAC_BITS:0]       quo_q;
	logic                     neg_q;
	logic [P_W-1:0]           prod_q;

	// output registers
	logic                 drive_en_q;
	logic [PULSE_W-1:0]   pulse_q [3];
	logic                 stopped_q;

	// ---- stick normalisation front end ----
	logic [ADC_BITS-1:0]      raw_sel;
	logic signed [ADC_BITS:0] delta;
	logic [ADC_BITS:0]        delta_neg;
	logic [ADC_BITS-1:0]      mag;
	logic signed [ADC_BITS:0] span;
	logic [ADC_BITS:0]        two_span;
	logic                     mag_zero;
	logic                     in_dz;
	logic                     delta_pos;
	logic                     span_pos;
	logic                     mag_ge_2span;
	logic                     norm_direct;
	logic signed [Q_W-1:0]    v_direct;

	assign raw_sel   = raw_q[idx_q];
	assign delta     = $signed({1'b0, raw_sel}) - $signed({1'b0, neutral_q});
	assign delta_neg = -delta;
	assign mag       = delta[ADC_BITS] ? delta_neg[ADC_BITS-1:0] : delta[ADC_BITS-1:0];
	assign span      = $signed({1'b0, upper_q}) - $signed({1'b0, neutral_q});
	assign two_span  = {span[ADC_BITS-1:0], 1'b0};
	assign mag_zero  = (mag == '0);
	assign in_dz     = (mag < {1'b0, dz_q});
	assign delta_pos = !delta[ADC_BITS] && !mag_zero;
	assign span_pos  = !span[ADC_BITS] && (span[ADC_BITS-1:0] != '0);
	assign mag_ge_2span = ({1'b0, mag} >= two_span);
	assign norm_direct  = mag_zero || in_dz || (delta_pos && (!span_pos || mag_ge_2span));

	always_comb begin
		if (mag_zero || in_dz) begin
			v_direct = '0;
		end else if (!span_pos) begin
			v_direct = Q_ONE_Q;
		end else begin
			v_direct = Q_HI_Q;
		end
	end

	// ---- shared restoring divider, one quotient bit a cycle ----
	logic [DW:0]          r2;
	logic [DW:0]          r2_sub;
	logic                 div_ge;
	logic [DW-1:0]        rem_nx;
	logic [FRAC_BITS:0]   quo_nx;
	logic [FRAC_BITS:0]   num_nx;
	logic signed [Q_W-1:0] qv_pos;
	logic signed [Q_W-1:0] v_div;
	logic signed [M_W-1:0] qm_pos;
	logic signed [M_W-1:0] m_div;

	assign r2     = {rem_q, num_q[FRAC_BITS]};
	assign div_ge = (r2 >= {1'b0, dvs_q});
	assign r2_sub = r2 - {1'b0, dvs_q};
	assign rem_nx = div_ge ? r2_sub[DW-1:0] : r2[DW-1:0];
	assign quo_nx = {quo_q[FRAC_BITS-1:0], div_ge};
	assign num_nx = {num_q[FRAC_BITS-1:0], 1'b0};
	assign qv_pos = $signed({2'b00, quo_nx});
	assign v_div  = neg_q ? -qv_pos : qv_pos;
	assign qm_pos = $signed({4'b0000, quo_nx});
	assign m_div  = neg_q ? -qm_pos : qm_pos;

	// wheel rescale operand
	logic signed [M_W-1:0] m_sel;
	logic [M_W-1:0]        m_sel_abs;

	assign m_sel     = m_q[idx_q];
	assign m_sel_abs = abs_m(m_sel);

	// ---- shared multiplier ----
	logic [Q_W-1:0]        v_abs1;
	logic [Q_W-1:0]        v_abs2;
	logic signed [M_W-1:0] m_clamp;
	logic signed [M_W-1:0] m_plus;
	logic [MA_W-1:0]       mul_a;
	logic [MB_W-1:0]       mul_b;
	logic [P_W-1:0]        prod;

	assign v_abs1 = abs_q(v_q[1]);
	assign v_abs2 = abs_q(v_q[2]);

	always_comb begin
		if (m_sel > Q_ONE_M) begin
			m_clamp = Q_ONE_M;
		end else if (m_sel < Q_MONE_M) begin
			m_clamp = Q_MONE_M;
		end else begin
			m_clamp = m_sel;
		end
	end

	assign m_plus = m_clamp + Q_ONE_M;

	always_comb begin
		unique case (state_q)
			S_MRW: begin
				mul_a = v_abs2[MA_W-1:0];
				mul_b = MB_W'(gain_q);
			end
			S_MSY: begin
				mul_a = v_abs1[MA_W-1:0];
				mul_b = K_866;
			end
			default: begin
				mul_a = m_plus[MA_W-1:0];
				mul_b = PULSE_SCALE;
			end
		endcase
	end

	assign prod = P_W'(mul_a) * P_W'(mul_b);

	// ---- mix terms ----
	logic [P_W-1:0]        rw_sh;
	logic signed [Q_W-1:0] rw_pos;
	logic signed [Q_W-1:0] rw_val;
	logic [P_W-1:0]        sy_sh;
	logic signed [Q_W-1:0] sy_pos;
	logic signed [Q_W-1:0] sy_val;
	logic signed [Q_W-1:0] hx;
	logic signed [M_W-1:0] vx_e;
	logic signed [M_W-1:0] rw_e;
	logic signed [M_W-1:0] sy_e;
	logic signed [M_W-1:0] hx_e;
	logic signed [M_W-1:0] m0;
	logic signed [M_W-1:0] m1;
	logic signed [M_W-1:0] m2;
	logic [M_W-1:0]        a0;
	logic [M_W-1:0]        a1;
	logic [M_W-1:0]        a2;
	logic [M_W-1:0]        big;
	logic                  big_gt_one;

	// rotation product scaled by 2^16, truncated toward zero
	assign rw_sh  = prod_q >> GAIN_SH;
	assign rw_pos = $signed({1'b0, rw_sh[Q_W-2:0]});
	assign rw_val = v_q[2][Q_W-1] ? -rw_pos : rw_pos;

	// sine term scaled by 2^FRAC_BITS, truncated toward zero
	assign sy_sh  = prod_q >> FRAC_BITS;
	assign sy_pos = $signed({1'b0, sy_sh[Q_W-2:0]});
	assign sy_val = v_q[1][Q_W-1] ? -sy_pos : sy_pos;

	// x/2 rounding toward zero
	assign hx = (v_q[0] + $signed({{(Q_W-1){1'b0}}, v_q[0][Q_W-1]})) >>> 1;

	assign vx_e = M_W'(v_q[0]);
	assign rw_e = M_W'(rw_q);
	assign sy_e = M_W'(sy_val);
	assign hx_e = M_W'(hx);
	assign m0   = vx_e + rw_e;
	assign m1   = sy_e - hx_e + rw_e;
	assign m2   = -sy_e - hx_e + rw_e;
	assign a0   = abs_m(m0);
	assign a1   = abs_m(m1);
	assign a2   = abs_m(m2);

	always_comb begin
		big = a0;
		if (a1 > big) begin
			big = a1;
		end
		if (a2 > big) begin
			big = a2;
		end
	end

	assign big_gt_one = (big > M_W'(Q_ONE_I));

	// pulse from the registered product
	logic [P_W-1:0]     p_sh;
	logic [PULSE_W-1:0] pulse_new;

	assign p_sh      = prod_q >> FRAC_BITS;
	assign pulse_new = PULSE_BASE + p_sh[PULSE_W-1:0];

	// ---- timeout ----
	logic [15:0] ms_inc;
	logic        tick_stop;
	logic        out_free;

	assign ms_inc    = (ms_q == 16'hFFFF) ? ms_q : ms_q + 16'd1;
	assign tick_stop = drive_q && (ms_inc > timeout_q);
	assign out_free  = !out_valid_q || out_ready;

	// ---- sequencer and control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			drive_q     <= 1'b0;
			ms_q        <= '0;
			wheel_q[0]  <= PULSE_MID;
			wheel_q[1]  <= PULSE_MID;
			wheel_q[2]  <= PULSE_MID;
			neutral_q   <= NEUTRAL_RST;
			dz_q        <= DZ_RST;
			upper_q     <= UPPER_RST;
			gain_q      <= GAIN_RST;
			timeout_q   <= TIMEOUT_RST;
		end else begin
			// register writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_NEUTRAL: neutral_q <= cfg_data[ADC_BITS-1:0];
					CFG_DZ:      dz_q      <= cfg_data[DZ_BITS-1:0];
					CFG_UPPER:   upper_q   <= cfg_data[ADC_BITS-1:0];
					CFG_GAIN:    gain_q    <= cfg_data[15:0];
					CFG_TIMEOUT: timeout_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			// result taken; a new one landing on the same edge is set in S_FIN
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= (command == CMD_TICK) ? S_FIN : S_NORM;
					end
				end
				S_NORM: begin
					if (norm_direct) begin
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= S_MRW;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						cnt_q   <= CNT_LAST;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (cnt_q == '0) begin
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= S_MRW;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_NORM;
						end
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_MRW: state_q <= S_MSY;
				S_MSY: state_q <= S_MIX;
				S_MIX: begin
					idx_q   <= '0;
					state_q <= big_gt_one ? S_WSET : S_PMUL;
				end
				S_WSET: begin
					cnt_q   <= CNT_LAST;
					state_q <= S_WDIV;
				end
				S_WDIV: begin
					if (cnt_q == '0) begin
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= S_PMUL;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_WSET;
						end
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_PMUL: state_q <= S_PWR;
				S_PWR: begin
					wheel_q[idx_q] <= pulse_new;
					if (idx_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_PMUL;
					end
				end
				S_FIN: begin
					if (out_free) begin
						if (cmd_q == CMD_SAMPLE) begin
							drive_q <= 1'b1;
							ms_q    <= '0;
						end else begin
							ms_q    <= ms_inc;
							drive_q <= drive_q && !tick_stop;
						end
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q    <= command;
					raw_q[0] <= raw_x;
					raw_q[1] <= raw_y;
					raw_q[2] <= raw_z;
				end
			end
			S_NORM: begin
				if (norm_direct) begin
					v_q[idx_q] <= v_direct;
				end else begin
					rem_q <= DW'(mag >> 1);
					num_q <= {mag[0], {FRAC_BITS{1'b0}}};
					dvs_q <= delta_pos ? DW'(span[ADC_BITS-1:0]) : DW'(neutral_q);
					neg_q <= !delta_pos;
				end
			end
			S_NDIV: begin
				rem_q <= rem_nx;
				num_q <= num_nx;
				quo_q <= quo_nx;
				if (cnt_q == '0) begin
					v_q[idx_q] <= v_div;
				end
			end
			S_MRW: prod_q <= prod;
			S_MSY: begin
				rw_q   <= rw_val;
				prod_q <= prod;
			end
			S_MIX: begin
				m_q[0] <= m0;
				m_q[1] <= m1;
				m_q[2] <= m2;
				big_q  <= DW'(big);
			end
			S_WSET: begin
				rem_q <= DW'(m_sel_abs >> 1);
				num_q <= {m_sel_abs[0], {FRAC_BITS{1'b0}}};
				dvs_q <= big_q;
				neg_q <= m_sel[M_W-1];
			end
			S_WDIV: begin
				rem_q <= rem_nx;
				num_q <= num_nx;
				quo_q <= quo_nx;
				if (cnt_q == '0) begin
					m_q[idx_q] <= m_div;
				end
			end
			S_PMUL: prod_q <= prod;
			S_FIN: begin
				if (out_free) begin
					drive_en_q <= (cmd_q == CMD_SAMPLE) ? 1'b1 : (drive_q && !tick_stop);
					stopped_q  <= (cmd_q == CMD_TICK) && tick_stop;
					pulse_q[0] <= wheel_q[0];
					pulse_q[1] <= wheel_q[1];
					pulse_q[2] <= wheel_q[2];
				end
			end
			default: ;
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign drive_enable = drive_en_q;
	assign pulse_top    = pulse_q[0];
	assign pulse_left   = pulse_q[1];
	assign pulse_right  = pulse_q[2];
	assign stopped_now  = stopped_q;

`ifndef NO_ASSERTIONS
	// a timeout stop always reports the drive as off
	a_stop_drops_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && stopped_now) |-> !drive_enable)
		else $error("stop reported with drive still enabled");

	// pulses stay within the servo range
	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pulse_top >= PULSE_BASE) && (pulse_top <= 11'd2000) &&
			(pulse_left >= PULSE_BASE) && (pulse_left <= 11'd2000) &&
			(pulse_right >= PULSE_BASE) && (pulse_right <= 11'd2000))
		else $error("wheel pulse out of range");

	// wheel rescale only runs with a divisor above one
	a_rescale_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WDIV) |-> (dvs_q > DW'(Q_ONE_I)))
		else $error("wheel rescale with divisor not above one");

	// drive comes on only with a sample, which clears the timeout counter
	a_drive_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_q) |-> (ms_q == '0))
		else $error("drive enabled without counter cleared");

	// the result register is never overwritten while still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && (state_q == S_FIN)) |=> (state_q == S_FIN))
		else $error("result overwritten while stalled");
`endif

endmodule

>>> bench/kiwi_drive_wheel_mixer_tb.sv
// ----------------------------------------------------------------------------
// kiwi_drive_wheel_mixer_tb - self-checking bench for the kiwi drive mixer
// A scripted opening covers stick extremes, the dead zone edge, spans that
// are not positive or are overrun, and the timeout stop. Random phases
// follow, each with its own register settings. Every result is compared with
// its typed script value or a built-in fixed-point model of mixer and timeout.
// ----------------------------------------------------------------------------
module kiwi_drive_wheel_mixer_tb;
	import kdwm_pkg::*;

	localparam longint Q1          = longint'(1) << FRAC_BITS;
	localparam longint K866        = (866 * Q1) / 1000;
	localparam int     ADC_MAX     = (1 << ADC_BITS) - 1;
	localparam int     DZ_MAX      = (1 << DZ_BITS) - 1;
	localparam int     IDLE_PCT    = 29;
	localparam int     HOLD_CYCLES = 400;
	localparam int     PHASES      = 8;
	localparam int     PHASE_ITEMS = 80;
	localparam int     CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic               drive;
		logic [PULSE_W-1:0] p_top;
		logic [PULSE_W-1:0] p_left;
		logic [PULSE_W-1:0] p_right;
		logic               stop;
	} wheel_result_t;

	typedef enum logic [1:0] {STEP_PREDICT, STEP_TYPED, STEP_WRITE} step_kind_t;

	typedef struct packed {
		step_kind_t           kind;
		logic                 cmd;
		logic [ADC_BITS-1:0]  x;
		logic [ADC_BITS-1:0]  y;
		logic [ADC_BITS-1:0]  z;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
		wheel_result_t        res;
	} drive_step_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 command;
	logic [ADC_BITS-1:0]  raw_x;
	logic [ADC_BITS-1:0]  raw_y;
	logic [ADC_BITS-1:0]  raw_z;
	logic                 out_valid;
	logic                 out_ready;
	logic                 drive_enable;
	logic [PULSE_W-1:0]   pulse_top;
	logic [PULSE_W-1:0]   pulse_left;
	logic [PULSE_W-1:0]   pulse_right;
	logic                 stopped_now;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// mirror of the block's registers and state
	logic [ADC_BITS-1:0]  cfg_neutral;
	logic [DZ_BITS-1:0]   cfg_dead_zone;
	logic [ADC_BITS-1:0]  cfg_upper;
	logic [15:0]          cfg_gain;
	logic [15:0]          cfg_timeout;
	logic                 drive_on;
	logic [15:0]          ms_count;
	logic [PULSE_W-1:0]   held_pulse [3];

	wheel_result_t pending_wheel_results [$];
	drive_step_t   drive_script [$];

	int tx_idle_pct = IDLE_PCT;
	int rx_idle_pct = IDLE_PCT;
	int hold_asked  = 0;
	int hold_served = 0;
	int fail_count  = 0;
	int cycles      = 0;
	int samples_sent    = 0;
	int ticks_sent      = 0;
	int results_checked = 0;
	int stops_seen      = 0;
	int writes_done     = 0;

	kiwi_drive_wheel_mixer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.raw_x        (raw_x),
		.raw_y        (raw_y),
		.raw_z        (raw_z),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.drive_enable (drive_enable),
		.pulse_top    (pulse_top),
		.pulse_left   (pulse_left),
		.pulse_right  (pulse_right),
		.stopped_now  (stopped_now),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ---- fixed-point model ----

	function automatic longint q_sat(longint v);
		if (v > 2 * Q1 - 1)
			return 2 * Q1 - 1;
		if (v < -2 * Q1)
			return -2 * Q1;
		return v;
	endfunction

	// product scaled down, truncated toward zero
	function automatic longint scaled_product(longint a, longint b, int sh);
		longint p;
		p = a * b;
		if (p < 0)
			return -((-p) >> sh);
		return p >> sh;
	endfunction

	function automatic longint stick_value(logic [ADC_BITS-1:0] raw);
		longint neu, delta, mag, span;
		neu   = longint'(cfg_neutral);
		delta = longint'(raw) - neu;
		mag   = (delta < 0) ? -delta : delta;
		if (mag < longint'(cfg_dead_zone))
			return 0;
		if (delta > 0) begin
			span = longint'(cfg_upper) - neu;
			// upper span not positive: full deflection
			if (span <= 0)
				return Q1;
			return q_sat((delta * Q1) / span);
		end
		return q_sat(-((mag * Q1) / neu));
	endfunction

	function automatic logic [PULSE_W-1:0] pulse_width(longint m);
		if (m > Q1)
			m = Q1;
		if (m < -Q1)
			m = -Q1;
		return PULSE_W'(1000 + (((m + Q1) * 500) >> FRAC_BITS));
	endfunction

	function automatic wheel_result_t mix_wheels(logic cmd, logic [ADC_BITS-1:0] x,
		logic [ADC_BITS-1:0] y, logic [ADC_BITS-1:0] z);
		wheel_result_t r;
		longint vx, vy, om, rw, hx, sy, big, a;
		longint m [3];
		int i;
		r.stop = 1'b0;
		if (cmd == CMD_SAMPLE) begin
			vx = stick_value(x);
			vy = stick_value(y);
			om = stick_value(z);
			rw = scaled_product(om, longint'(cfg_gain), GAIN_SH);
			hx = vx / 2;
			sy = scaled_product(vy, K866, FRAC_BITS);
			m[0] = vx + rw;
			m[1] = sy - hx + rw;
			m[2] = -sy - hx + rw;
			big = 0;
			for (i = 0; i < 3; i++) begin
				a = (m[i] < 0) ? -m[i] : m[i];
				if (a > big)
					big = a;
			end
			// rescale all three when the largest exceeds one
			for (i = 0; i < 3; i++) begin
				if (big > Q1)
					m[i] = (m[i] * Q1) / big;
				held_pulse[i] = pulse_width(m[i]);
			end
			drive_on = 1'b1;
			ms_count = '0;
		end else begin
			if (ms_count != 16'hFFFF)
				ms_count++;
			if (drive_on && ms_count > cfg_timeout) begin
				drive_on = 1'b0;
				r.stop   = 1'b1;
			end
		end
		r.drive   = drive_on;
		r.p_top   = held_pulse[0];
		r.p_left  = held_pulse[1];
		r.p_right = held_pulse[2];
		return r;
	endfunction

	function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		case (idx)
			CFG_NEUTRAL: cfg_neutral   = val[ADC_BITS-1:0];
			CFG_DZ:      cfg_dead_zone = val[DZ_BITS-1:0];
			CFG_UPPER:   cfg_upper     = val[ADC_BITS-1:0];
			CFG_GAIN:    cfg_gain      = val[15:0];
			CFG_TIMEOUT: cfg_timeout   = val[15:0];
			default: ;
		endcase
	endfunction

	// ---- script rows ----

	task automatic row_item(input logic cmd, input int x, input int y, input int z);
		drive_step_t s;
		s      = '0;
		s.kind = STEP_PREDICT;
		s.cmd  = cmd;
		s.x    = ADC_BITS'(x);
		s.y    = ADC_BITS'(y);
		s.z    = ADC_BITS'(z);
		drive_script.push_back(s);
	endtask

	task automatic row_typed(input logic cmd, input int x, input int y, input int z,
		input logic drv, input int pt, input int pl, input int pr, input logic stp);
		drive_step_t s;
		s             = '0;
		s.kind        = STEP_TYPED;
		s.cmd         = cmd;
		s.x           = ADC_BITS'(x);
		s.y           = ADC_BITS'(y);
		s.z           = ADC_BITS'(z);
		s.res.drive   = drv;
		s.res.p_top   = PULSE_W'(pt);
		s.res.p_left  = PULSE_W'(pl);
		s.res.p_right = PULSE_W'(pr);
		s.res.stop    = stp;
		drive_script.push_back(s);
	endtask

	task automatic row_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		drive_step_t s;
		s      = '0;
		s.kind = STEP_WRITE;
		s.idx  = idx;
		s.val  = CFG_W'(val);
		drive_script.push_back(s);
	endtask

	// ---- channel drivers ----

	task automatic idle_gap();
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// offer one item, record its expected result once accepted
	task automatic send_item(input logic cmd, input logic [ADC_BITS-1:0] x,
		input logic [ADC_BITS-1:0] y, input logic [ADC_BITS-1:0] z,
		input logic typed, input wheel_result_t typed_res);
		wheel_result_t r;
		in_valid <= 1'b1;
		command  <= cmd;
		raw_x    <= x;
		raw_y    <= y;
		raw_z    <= z;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = mix_wheels(cmd, x, y, z);
		if (typed)
			r = typed_res;
		pending_wheel_results.push_back(r);
		if (r.stop)
			stops_seen++;
		if (cmd == CMD_SAMPLE)
			samples_sent++;
		else
			ticks_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		model_write(idx, CFG_W'(val));
		writes_done++;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_wheel_results.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_settings(input int n, input int d, input int u, input int g,
		input int t);
		wait_all_results();
		write_reg(CFG_NEUTRAL, n);
		write_reg(CFG_DZ, d);
		write_reg(CFG_UPPER, u);
		write_reg(CFG_GAIN, g);
		write_reg(CFG_TIMEOUT, t);
		cfg_valid <= 1'b0;
	endtask

	// ---- random values ----

	function automatic int pick_value(int lo, int hi);
		case ($urandom_range(9))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic logic [ADC_BITS-1:0] sample_reading();
		int v, neu, dz;
		neu = cfg_neutral;
		dz  = cfg_dead_zone;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom_range(ADC_MAX);
			4:          v = neu + dz + int'($urandom_range(4)) - 2;
			5:          v = neu - dz + int'($urandom_range(4)) - 2;
			6:          v = 0;
			7:          v = ADC_MAX;
			8:          v = int'(cfg_upper) + int'($urandom_range(64)) - 32;
			default:    v = neu - dz + int'($urandom_range(2 * dz));
		endcase
		if (v < 0)
			v = 0;
		if (v > ADC_MAX)
			v = ADC_MAX;
		return ADC_BITS'(v);
	endfunction

	task automatic random_settings();
		int n, d, u, g, t;
		n = $urandom_range(1) ? $urandom_range(2300, 1700) : pick_value(0, ADC_MAX);
		d = $urandom_range(1) ? $urandom_range(300) : pick_value(0, DZ_MAX);
		u = $urandom_range(1) ? $urandom_range(ADC_MAX, ADC_MAX - 200) : pick_value(1, ADC_MAX);
		g = pick_value(0, 65535);
		case ($urandom_range(5))
			0:       t = 1;
			1:       t = 65535;
			2:       t = $urandom_range(300, 11);
			default: t = $urandom_range(10, 2);
		endcase
		// a zero neutral needs a dead zone so a reading at neutral stays zero
		if (n == 0 && d == 0)
			d = 1;
		apply_settings(n, d, u, g, t);
	endtask

	// ---- result side: random stalls, one long hold-off on request ----
	initial begin : result_sink
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served++;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		wheel_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_wheel_results.size() == 0) begin
				$error("result arrived with nothing expected");
				fail_count++;
			end else begin
				want = pending_wheel_results.pop_front();
				results_checked++;
				if (drive_enable !== want.drive) begin
					$error("drive_enable: expected %0d, actual %0d", want.drive, drive_enable);
					fail_count++;
				end
				if (pulse_top !== want.p_top) begin
					$error("pulse_top: expected %0d, actual %0d", want.p_top, pulse_top);
					fail_count++;
				end
				if (pulse_left !== want.p_left) begin
					$error("pulse_left: expected %0d, actual %0d", want.p_left, pulse_left);
					fail_count++;
				end
				if (pulse_right !== want.p_right) begin
					$error("pulse_right: expected %0d, actual %0d", want.p_right, pulse_right);
					fail_count++;
				end
				if (stopped_now !== want.stop) begin
					$error("stopped_now: expected %0d, actual %0d", want.stop, stopped_now);
					fail_count++;
				end
			end
		end
	end

	// ---- stimulus ----
	initial begin : stimulus
		int phase, sent, burst, kind, i;
		logic paused;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_SAMPLE;
		raw_x     = '0;
		raw_y     = '0;
		raw_z     = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_NEUTRAL;
		cfg_data  = '0;
		paused    = 1'b0;

		// state after reset
		cfg_neutral   = NEUTRAL_RST;
		cfg_dead_zone = DZ_RST;
		cfg_upper     = UPPER_RST;
		cfg_gain      = GAIN_RST;
		cfg_timeout   = TIMEOUT_RST;
		drive_on      = 1'b0;
		ms_count      = '0;
		for (i = 0; i < 3; i++)
			held_pulse[i] = PULSE_MID;

		// opening script, reset settings first
		row_typed(CMD_TICK, 4095, 0, 2748, 1'b0, 1500, 1500, 1500, 1'b0);
		row_typed(CMD_SAMPLE, 2010, 2010, 2010, 1'b1, 1500, 1500, 1500, 1'b0);
		row_typed(CMD_SAMPLE, 0, 2010, 2010, 1'b1, 1000, 1750, 1750, 1'b0);
		row_typed(CMD_SAMPLE, 2010, 2010, 0, 1'b1, 1250, 1250, 1250, 1'b0);
		// just inside the dead zone on both sides
		row_typed(CMD_SAMPLE, 2209, 1811, 2010, 1'b1, 1500, 1500, 1500, 1'b0);
		row_item(CMD_SAMPLE, 2210, 1810, 2210);
		row_item(CMD_SAMPLE, 4095, 4095, 4095);
		row_item(CMD_SAMPLE, 0, 0, 0);
		row_item(CMD_SAMPLE, 4095, 0, 2010);
		row_item(CMD_SAMPLE, 2010, 4095, 4095);
		row_item(CMD_SAMPLE, 2730, 1365, 2730);
		row_item(CMD_TICK, 4095, 4095, 4095);
		// short timeout: stop on the third tick, pulses held
		row_write(CFG_TIMEOUT, 2);
		row_typed(CMD_SAMPLE, 0, 2010, 2010, 1'b1, 1000, 1750, 1750, 1'b0);
		row_typed(CMD_TICK, 0, 0, 0, 1'b1, 1000, 1750, 1750, 1'b0);
		row_typed(CMD_TICK, 0, 0, 0, 1'b1, 1000, 1750, 1750, 1'b0);
		row_typed(CMD_TICK, 0, 0, 0, 1'b0, 1000, 1750, 1750, 1'b1);
		row_typed(CMD_TICK, 0, 0, 0, 1'b0, 1000, 1750, 1750, 1'b0);
		// zero timeout: first tick stops
		row_write(CFG_TIMEOUT, 0);
		row_typed(CMD_SAMPLE, 2010, 2010, 2010, 1'b1, 1500, 1500, 1500, 1'b0);
		row_typed(CMD_TICK, 0, 0, 0, 1'b0, 1500, 1500, 1500, 1'b1);
		// upper level below neutral: positive offset reads as full scale
		row_write(CFG_UPPER, 1000);
		row_write(CFG_TIMEOUT, 65535);
		row_typed(CMD_SAMPLE, 4095, 2010, 2010, 1'b1, 2000, 1250, 1250, 1'b0);
		// narrow span: offsets beyond it saturate
		row_write(CFG_UPPER, 2100);
		row_item(CMD_SAMPLE, 4095, 2010, 2010);
		row_item(CMD_SAMPLE, 2150, 2010, 2300);
		row_write(CFG_NEUTRAL, 0);
		row_write(CFG_DZ, 1);
		row_write(CFG_GAIN, 65535);
		row_write(CFG_UPPER, 4095);
		row_item(CMD_SAMPLE, 4095, 4095, 4095);
		row_typed(CMD_SAMPLE, 0, 0, 0, 1'b1, 1500, 1500, 1500, 1'b0);
		row_write(CFG_NEUTRAL, 4095);
		row_write(CFG_DZ, 2047);
		row_item(CMD_SAMPLE, 0, 2048, 2047);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drive_script[k]) begin
			if (drive_script[k].kind == STEP_WRITE) begin
				wait_all_results();
				write_reg(drive_script[k].idx, drive_script[k].val);
				cfg_valid <= 1'b0;
			end else begin
				idle_gap();
				send_item(drive_script[k].cmd, drive_script[k].x, drive_script[k].y,
					drive_script[k].z, drive_script[k].kind == STEP_TYPED,
					drive_script[k].res);
			end
		end

		// random phases, each under its own settings
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase == 0)
				apply_settings(2010, 200, 4020, 32768, 5);
			else
				random_settings();
			// phase 1 runs without any idling on either side
			tx_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
			rx_idle_pct = (phase == 1) ? 0 : IDLE_PCT;
			// phase 2: receiver holds off while items keep coming
			if (phase == 2)
				hold_asked++;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				// phase 4: sender pauses half way until everything is back
				if (phase == 4 && !paused && sent >= PHASE_ITEMS / 2) begin
					wait_all_results();
					paused = 1'b1;
				end
				kind = $urandom_range(99);
				if (kind < 55) begin
					idle_gap();
					send_item(CMD_SAMPLE, sample_reading(), sample_reading(), sample_reading(),
						1'b0, '0);
					sent++;
				end else begin
					// single tick, a run long enough to reach a short timeout, or a short run otherwise
					if (kind < 85)
						burst = 1;
					else if (cfg_timeout <= 12)
						burst = int'(cfg_timeout) + 1 + $urandom_range(2);
					else
						burst = $urandom_range(6, 2);
					repeat (burst) begin
						idle_gap();
						send_item(CMD_TICK, ADC_BITS'($urandom_range(ADC_MAX)),
							ADC_BITS'($urandom_range(ADC_MAX)),
							ADC_BITS'($urandom_range(ADC_MAX)), 1'b0, '0);
						sent++;
					end
				end
			end
		end

		wait_all_results();
		repeat (20) @(posedge clk);
		$display("covered %0d samples and %0d ticks over %0d random phases, %0d register writes",
			samples_sent, ticks_sent, PHASES, writes_done);
		$display("checked %0d results, %0d of them timeout stops, %0d mismatches",
			results_checked, stops_seen, fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
